@@ rtl/mtg_pkg.sv @@
// shared constants, types and functions of the mt19937 generator
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);
  localparam int WORD_W       = 32;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re_a;
    addr_t raddr_a;
    logic  re_b;
    addr_t raddr_b;
  } mem_ctl_t;

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t v;
    y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

endpackage

@@ rtl/mtg_if.sv @@
// request and response channel interfaces of the mt19937 generator
interface mtg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mtg_rsp_if;
  logic         valid;
  logic         ready;
  logic [31:0]  random_word;
  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

@@ rtl/mtg_state_store.sv @@
// state word memory: one write port, two registered read ports
module mtg_state_store (
  input  logic              clk,
  input  mtg_pkg::mem_ctl_t ctl,
  output mtg_pkg::word_t    rdata_a,
  output mtg_pkg::word_t    rdata_b
);

  mtg_pkg::word_t mem [mtg_pkg::STATE_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re_a) begin
      rdata_a <= mem[ctl.raddr_a];
    end
    if (ctl.re_b) begin
      rdata_b <= mem[ctl.raddr_b];
    end
  end

endmodule

@@ rtl/mt19937_generator_unit.sv @@
// mt19937 generator top level: sequencer, seed register and output register
// A request returns one tempered 32-bit word. An ordinary draw reads the word
// from memory, then tempers it into the output register, which waits for room
// on the response channel. The first draw after a refill, and every 624th draw
// after it, first twists the whole state, one word at a time through the twist
// datapath. A request with restart set first refills the state from the seed
// register, one word at a time through the 32x32 multiplier, and is then
// followed by the twist. After reset the same refill runs from seed 5489 before
// the first request is taken. Seed writes take effect at the next restart;
// request ready is low while a draw is being worked on.
module mt19937_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  mtg_req_if.sink     req,
  mtg_rsp_if.source   rsp
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILL0 = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_ADD   = 4'd3;
  localparam logic [3:0] ST_TW0   = 4'd4;
  localparam logic [3:0] ST_TWR   = 4'd5;
  localparam logic [3:0] ST_TWW   = 4'd6;
  localparam logic [3:0] ST_RD    = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam mtg_pkg::addr_t LAST = mtg_pkg::ADDR_W'(mtg_pkg::STATE_WORDS - 1);
  localparam logic [mtg_pkg::ADDR_W:0] WRAP = (mtg_pkg::ADDR_W+1)'(mtg_pkg::STATE_WORDS);
  localparam logic [mtg_pkg::ADDR_W:0] OFFS = (mtg_pkg::ADDR_W+1)'(mtg_pkg::TWIST_OFFSET);

  logic [3:0]              state;
  mtg_pkg::addr_t          cnt;
  logic [mtg_pkg::ADDR_W:0] idx;
  mtg_pkg::word_t          seed;
  mtg_pkg::word_t          w;
  mtg_pkg::word_t          p;
  mtg_pkg::word_t          cur;
  logic                    draw_pend;
  logic                    out_valid;
  mtg_pkg::word_t          out_word;

  mtg_pkg::mem_ctl_t       mem_ctl;
  mtg_pkg::word_t          rd_a;
  mtg_pkg::word_t          rd_b;

  mtg_pkg::word_t          mul_out;
  mtg_pkg::word_t          w_add;
  mtg_pkg::word_t          tw_out;
  mtg_pkg::addr_t          k_next;
  mtg_pkg::addr_t          k_far;
  logic [mtg_pkg::ADDR_W:0] far_sum;
  logic                    out_load;

  mtg_state_store u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign mul_out  = (w ^ (w >> 30)) * mtg_pkg::SEED_MULT;
  assign w_add    = p + mtg_pkg::WORD_W'(cnt);
  assign tw_out   = mtg_pkg::twist_word(cur, rd_a, rd_b);
  assign k_next   = (cnt == LAST) ? '0 : cnt + 1'b1;
  assign far_sum  = {1'b0, cnt} + OFFS;
  assign k_far    = (far_sum >= WRAP) ? mtg_pkg::ADDR_W'(far_sum - WRAP)
                                      : far_sum[mtg_pkg::ADDR_W-1:0];
  assign out_load = (state == ST_OUT) && (!out_valid || rsp.ready);

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  always_comb begin
    mem_ctl = '0;
    unique case (state)
      ST_FILL0: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = '0;
        mem_ctl.wdata = seed;
      end
      ST_ADD: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = cnt;
        mem_ctl.wdata = w_add;
      end
      ST_TW0: begin
        mem_ctl.re_a    = 1'b1;
        mem_ctl.raddr_a = '0;
      end
      ST_TWR: begin
        mem_ctl.re_a    = 1'b1;
        mem_ctl.raddr_a = k_next;
        mem_ctl.re_b    = 1'b1;
        mem_ctl.raddr_b = k_far;
      end
      ST_TWW: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = cnt;
        mem_ctl.wdata = tw_out;
      end
      ST_RD: begin
        mem_ctl.re_a    = 1'b1;
        mem_ctl.raddr_a = idx[mtg_pkg::ADDR_W-1:0];
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL0;
      draw_pend <= 1'b0;
      out_valid <= 1'b0;
      seed      <= mtg_pkg::SEED_RESET;
      idx       <= WRAP;
      cnt       <= '0;
    end else begin
      if (seed_we) begin
        seed <= seed_wdata;
      end
      if (rsp.valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            draw_pend <= req.restart;
            if (req.restart) begin
              state <= ST_FILL0;
            end else if (idx == WRAP) begin
              state <= ST_TW0;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_FILL0: begin
          w     <= seed;
          cnt   <= mtg_pkg::ADDR_W'(1);
          state <= ST_MUL;
        end
        ST_MUL: begin
          p     <= mul_out;
          state <= ST_ADD;
        end
        ST_ADD: begin
          w <= w_add;
          if (cnt == LAST) begin
            idx       <= WRAP;
            draw_pend <= 1'b0;
            state     <= draw_pend ? ST_TW0 : ST_IDLE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_TW0: begin
          cnt   <= '0;
          state <= ST_TWR;
        end
        ST_TWR: begin
          cur   <= rd_a;
          state <= ST_TWW;
        end
        ST_TWW: begin
          if (cnt == LAST) begin
            idx   <= '0;
            state <= ST_RD;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_TWR;
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_word  <= mtg_pkg::temper(rd_a);
            out_valid <= 1'b1;
            idx       <= idx + 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/mt_word_tracker_pkg.sv @@
// scoreboard class that predicts and checks the generator's tempered words
package mt_word_tracker_pkg;

  class mt_word_tracker;
    mtg_pkg::word_t words[mtg_pkg::STATE_WORDS];
    int unsigned    pos;
    mtg_pkg::word_t seed;
    mtg_pkg::word_t pending[$];
    int unsigned    mismatches;

    function new();
      seed       = mtg_pkg::SEED_RESET;
      mismatches = 0;
      refill();
    endfunction

    function void load_seed(mtg_pkg::word_t value);
      seed = value;
    endfunction

    function void refill();
      mtg_pkg::word_t w;
      w        = seed;
      words[0] = w;
      for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
        w        = mtg_pkg::SEED_MULT * (w ^ (w >> 30)) + mtg_pkg::word_t'(i);
        words[i] = w;
      end
      pos = mtg_pkg::STATE_WORDS;
    endfunction

    function void twist();
      mtg_pkg::word_t y;
      mtg_pkg::word_t v;
      for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
        y = {words[k][mtg_pkg::WORD_W-1],
             words[(k + 1) % mtg_pkg::STATE_WORDS][mtg_pkg::WORD_W-2:0]};
        v = words[(k + mtg_pkg::TWIST_OFFSET) % mtg_pkg::STATE_WORDS] ^ (y >> 1);
        if (y[0]) begin
          v = v ^ mtg_pkg::TWIST_MATRIX;
        end
        words[k] = v;
      end
      pos = 0;
    endfunction

    function mtg_pkg::word_t tempered(mtg_pkg::word_t x);
      mtg_pkg::word_t y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
      return y ^ (y >> 18);
    endfunction

    function void note_draw(bit restart);
      if (restart) begin
        refill();
      end
      if (pos >= mtg_pkg::STATE_WORDS) begin
        twist();
      end
      pending.push_back(tempered(words[pos]));
      pos++;
    endfunction

    function void check_word(mtg_pkg::word_t got);
      mtg_pkg::word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word %08h with no request waiting", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("random_word mismatch: expected %08h, got %08h", want, got);
        end
      end
    endfunction
  endclass

endpackage

@@ test/testbench.sv @@
// testbench for the mt19937 generator unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst;
  logic           seed_we;
  mtg_pkg::word_t seed_wdata;
  bit             steady;
  int             stall_left;
  int             sent;

  mtg_req_if req_ch();
  mtg_rsp_if rsp_ch();

  mt_word_tracker_pkg::mt_word_tracker tracker;

  mt19937_generator_unit uut (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // response stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_word(rsp_ch.random_word);
    end
  end

  task automatic send_draw(bit restart);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_draw(restart);
    sent++;
  endtask

  task automatic settle_pending();
    req_ch.valid <= 1'b0;
    while (tracker.pending.size() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_seed(mtg_pkg::word_t value);
    @(posedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we    <= 1'b0;
    tracker.load_seed(value);
  endtask

  function automatic mtg_pkg::word_t pick_seed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return mtg_pkg::word_t'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    tracker        = new();
    steady         = 1'b0;
    stall_left     = 0;
    sent           = 0;
    rst            = 1'b1;
    seed_we        = 1'b0;
    seed_wdata     = '0;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    rsp_ch.ready   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default seed, then restart from it
    repeat (3) send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);

    // zero seed: old state continues until restart
    settle_pending();
    write_seed('0);
    send_draw(1'b0);
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);

    settle_pending();
    write_seed('1);
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);

    // back-to-back restarts
    settle_pending();
    write_seed(mtg_pkg::word_t'($urandom));
    send_draw(1'b1);
    send_draw(1'b1);
    send_draw(1'b0);

    // long run from a restart, twisting the state twice
    settle_pending();
    write_seed(mtg_pkg::word_t'($urandom));
    send_draw(1'b1);
    repeat (699) send_draw(1'b0);

    while (sent < 1165) begin
      settle_pending();
      write_seed(pick_seed());
      n = $urandom_range(40, 300);
      for (int j = 0; j < n && sent < 1165; j++) begin
        steady = (sent >= 1015);
        if (j == 0) begin
          send_draw(1'($urandom_range(0, 1)));
        end else begin
          send_draw($urandom_range(0, 63) == 0);
        end
      end
    end

    settle_pending();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mtg_pkg.sv
rtl/mtg_if.sv
rtl/mtg_state_store.sv
rtl/mt19937_generator_unit.sv
test/mt_word_tracker_pkg.sv
test/testbench.sv
